// ----- design/lgc_pkg.sv -----
`default_nettype none

package lgc_pkg;

	localparam int OP_W     = 2;
	localparam int FONT_W   = 8;
	localparam int GLYPH_W  = 21;
	localparam int SIZE_W   = 10;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 6;
	localparam int REM_W    = 7;
	localparam int CAP_W    = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// request operations
	localparam logic [OP_W-1:0] OP_LOOKUP        = 2'd0;
	localparam logic [OP_W-1:0] OP_UNCACHE_GLYPH = 2'd1;
	localparam logic [OP_W-1:0] OP_UNCACHE_FONT  = 2'd2;
	localparam logic [OP_W-1:0] OP_CHECK_SIZE    = 2'd3;

	// response status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic reg_en;
		logic clear_en;
		logic size_en;
	} font_cmd_t;

	typedef struct packed {
		logic found;
		logic size_match;
		logic full;
	} font_res_t;

endpackage

`default_nettype wire

// ----- design/lgc_req_if.sv -----
`default_nettype none

interface lgc_req_if;
	logic                         valid;
	logic                         ready;
	logic [lgc_pkg::OP_W-1:0]     op;
	logic [lgc_pkg::FONT_W-1:0]   font_id;
	logic [lgc_pkg::GLYPH_W-1:0]  glyph;
	logic [lgc_pkg::SIZE_W-1:0]   font_size;

	modport source (output valid, op, font_id, glyph, font_size, input ready);
	modport sink (input valid, op, font_id, glyph, font_size, output ready);
endinterface

`default_nettype wire

// ----- design/lgc_rsp_if.sv -----
`default_nettype none

interface lgc_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [lgc_pkg::STATUS_W-1:0]  status;
	logic                          hit;
	logic [lgc_pkg::SLOT_W-1:0]    slot;
	logic                          evicted_valid;
	logic [lgc_pkg::FONT_W-1:0]    evicted_font;
	logic [lgc_pkg::GLYPH_W-1:0]   evicted_glyph;
	logic [lgc_pkg::REM_W-1:0]     removed_count;

	modport source (output valid, status, hit, slot, evicted_valid, evicted_font,
		evicted_glyph, removed_count, input ready);
	modport sink (input valid, status, hit, slot, evicted_valid, evicted_font,
		evicted_glyph, removed_count, output ready);
endinterface

`default_nettype wire

// ----- design/lgc_cfg_if.sv -----
`default_nettype none

interface lgc_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [lgc_pkg::CAP_W-1:0]  capacity;

	modport source (output valid, capacity, input ready);
	modport sink (input valid, capacity, output ready);
endinterface

`default_nettype wire

// ----- design/lgc_font_table.sv -----
`default_nettype none

module lgc_font_table #(
	parameter int FONTS = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [lgc_pkg::FONT_W-1:0]  font_id,
	input  wire logic [lgc_pkg::SIZE_W-1:0]  font_size,
	input  wire lgc_pkg::font_cmd_t          cmd,
	output lgc_pkg::font_res_t               res
);

	logic [FONTS-1:0]                known_q;
	logic [lgc_pkg::FONT_W-1:0]      tag_q [FONTS];
	logic [lgc_pkg::SIZE_W-1:0]      size_q [FONTS];

	logic [FONTS-1:0]                match;
	logic [FONTS-1:0]                free_oh;
	logic [lgc_pkg::SIZE_W-1:0]      size_seen;

	always_comb begin
		size_seen = '0;
		for (int i = 0; i < FONTS; i++) begin
			match[i] = known_q[i] && (tag_q[i] == font_id);
			if (match[i]) begin
				size_seen = size_seen | size_q[i];
			end
		end
		// lowest unused entry
		free_oh = ~known_q & (known_q + 1'b1);
	end

	assign res.found      = |match;
	assign res.size_match = (|match) && (size_seen == font_size);
	assign res.full       = &known_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_q <= '0;
		end else begin
			for (int i = 0; i < FONTS; i++) begin
				if (cmd.reg_en && free_oh[i]) begin
					known_q[i] <= 1'b1;
				end else if (cmd.clear_en && match[i]) begin
					known_q[i] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < FONTS; i++) begin
			if (cmd.reg_en && free_oh[i]) begin
				tag_q[i]  <= font_id;
				size_q[i] <= font_size;
			end else if (cmd.size_en && match[i]) begin
				size_q[i] <= font_size;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/lru_glyph_cache_tags.sv -----
// channel   role     payload                                               handshake
// req       sink     op, font_id, glyph, font_size                         valid/ready
// rsp       source   status, hit, slot, evicted_valid/_font/_glyph,        valid/ready
//                    removed_count
// cfg       sink     capacity                                              valid/ready
//
// one request enters per cycle unless a held one is still waiting; lookups, glyph uncache,
// size checks without change and font registration finish once the response register is free.
// a font flush (uncache font, size change) removes one slot per cycle through the
// single removal port of the age-rank update, and finishes once no glyph of the font is left.
// reset clears slot valid bits, used count and font table at once; no clearing pass.
// a finished response waits in the output register; a held request stalls while that
// register is full and not being taken, and while a font flush still has slots to remove.
`default_nettype none

module lru_glyph_cache_tags #(
	parameter int SLOTS = 64,
	parameter int FONTS = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lgc_req_if.sink    req,
	lgc_rsp_if.source  rsp,
	lgc_cfg_if.sink    cfg
);

	localparam int IDXW = $clog2(SLOTS);
	localparam int CW   = $clog2(SLOTS + 1);
	localparam int EW   = (CW > lgc_pkg::CAP_W) ? CW : lgc_pkg::CAP_W;

	// slot tag store
	logic [SLOTS-1:0]                 valid_q;
	logic [lgc_pkg::FONT_W-1:0]       font_q [SLOTS];
	logic [lgc_pkg::GLYPH_W-1:0]      cp_q [SLOTS];
	logic [IDXW-1:0]                  rank_q [SLOTS];
	logic [CW-1:0]                    used_q;
	logic [lgc_pkg::CAP_W-1:0]        capacity_q;

	// held request
	logic                             req_valid_q;
	logic [lgc_pkg::OP_W-1:0]         op_q;
	logic [lgc_pkg::FONT_W-1:0]       font_id_q;
	logic [lgc_pkg::GLYPH_W-1:0]      glyph_q;
	logic [lgc_pkg::SIZE_W-1:0]       font_size_q;
	logic [CW-1:0]                    rem_cnt_q;

	// response register
	logic                             out_valid_q;
	logic [lgc_pkg::STATUS_W-1:0]     status_q;
	logic                             hit_q;
	logic [lgc_pkg::SLOT_W-1:0]       slot_q;
	logic                             ev_valid_q;
	logic [lgc_pkg::FONT_W-1:0]       ev_font_q;
	logic [lgc_pkg::GLYPH_W-1:0]      ev_glyph_q;
	logic [lgc_pkg::REM_W-1:0]        rem_q;

	lgc_pkg::font_cmd_t               font_cmd;
	lgc_pkg::font_res_t               font_res;

	logic [SLOTS-1:0]                 gm;
	logic [SLOTS-1:0]                 fmm;
	logic [SLOTS-1:0]                 lm;
	logic [SLOTS-1:0]                 free_oh;
	logic [SLOTS-1:0]                 fpick_oh;
	logic [SLOTS-1:0]                 tgt_oh;
	logic [SLOTS-1:0]                 rm_oh;
	logic [IDXW-1:0]                  gidx;
	logic [IDXW-1:0]                  grank;
	logic [IDXW-1:0]                  frank;
	logic [IDXW-1:0]                  tidx;
	logic [IDXW-1:0]                  rm_rank;
	logic [IDXW-1:0]                  lru_rank;
	logic [lgc_pkg::FONT_W-1:0]       lru_font;
	logic [lgc_pkg::GLYPH_W-1:0]      lru_glyph;
	logic                             g_any;
	logic [EW-1:0]                    cap_eff;
	logic                             evict;

	logic                             is_lookup;
	logic                             is_uglyph;
	logic                             is_ufont;
	logic                             is_check;
	logic                             flush_mode;
	logic                             flush_step;
	logic                             out_free;
	logic                             finish;
	logic                             upd_hit;
	logic                             upd_fill;
	logic                             upd_rm;
	logic                             accept;

	logic [lgc_pkg::STATUS_W-1:0]     status_d;
	logic                             hit_d;
	logic [lgc_pkg::SLOT_W-1:0]       slot_d;
	logic                             ev_valid_d;
	logic [lgc_pkg::FONT_W-1:0]       ev_font_d;
	logic [lgc_pkg::GLYPH_W-1:0]      ev_glyph_d;
	logic [lgc_pkg::REM_W-1:0]        rem_d;

	lgc_font_table #(
		.FONTS (FONTS)
	) u_font_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.font_id   (font_id_q),
		.font_size (font_size_q),
		.cmd       (font_cmd),
		.res       (font_res)
	);

	// associative match and slot picks
	always_comb begin
		gidx      = '0;
		grank     = '0;
		frank     = '0;
		tidx      = '0;
		lru_font  = '0;
		lru_glyph = '0;
		lru_rank  = IDXW'(used_q - 1'b1);
		for (int i = 0; i < SLOTS; i++) begin
			gm[i]  = valid_q[i] && (font_q[i] == font_id_q) && (cp_q[i] == glyph_q);
			fmm[i] = valid_q[i] && (font_q[i] == font_id_q);
			// ranks form a permutation, so the oldest holds rank used-1
			lm[i]  = valid_q[i] && (rank_q[i] == lru_rank);
		end
		free_oh  = ~valid_q & (valid_q + 1'b1);
		fpick_oh = fmm & (~fmm + 1'b1);
		g_any    = |gm;

		cap_eff = EW'(capacity_q);
		if (capacity_q == '0) begin
			cap_eff = EW'(1);
		end else if (cap_eff > EW'(SLOTS)) begin
			cap_eff = EW'(SLOTS);
		end
		evict  = EW'(used_q) >= cap_eff;
		tgt_oh = evict ? lm : free_oh;

		for (int i = 0; i < SLOTS; i++) begin
			if (gm[i]) begin
				gidx  = gidx | IDXW'(i);
				grank = grank | rank_q[i];
			end
			if (fpick_oh[i]) begin
				frank = frank | rank_q[i];
			end
			if (tgt_oh[i]) begin
				tidx = tidx | IDXW'(i);
			end
			if (lm[i]) begin
				lru_font  = lru_font | font_q[i];
				lru_glyph = lru_glyph | cp_q[i];
			end
		end
	end

	// request control
	always_comb begin
		is_lookup = (op_q == lgc_pkg::OP_LOOKUP);
		is_uglyph = (op_q == lgc_pkg::OP_UNCACHE_GLYPH);
		is_ufont  = (op_q == lgc_pkg::OP_UNCACHE_FONT);
		is_check  = (op_q == lgc_pkg::OP_CHECK_SIZE);

		flush_mode = req_valid_q && font_res.found &&
			(is_ufont || (is_check && !font_res.size_match));
		flush_step = flush_mode && (|fmm);
		out_free   = !out_valid_q || rsp.ready;
		finish     = req_valid_q && out_free && !flush_step;

		upd_hit  = finish && is_lookup && font_res.found && g_any;
		upd_fill = finish && is_lookup && font_res.found && !g_any;
		upd_rm   = flush_step || (finish && is_uglyph && g_any);
		rm_oh    = flush_step ? fpick_oh : gm;
		rm_rank  = flush_step ? frank : grank;

		font_cmd.reg_en   = finish && is_check && !font_res.found && !font_res.full;
		font_cmd.clear_en = finish && is_ufont && font_res.found;
		font_cmd.size_en  = finish && is_check && font_res.found && !font_res.size_match;
	end

	assign req.ready = !req_valid_q || finish;
	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// response fields
	always_comb begin
		status_d   = lgc_pkg::ST_OK;
		hit_d      = 1'b0;
		slot_d     = '0;
		ev_valid_d = 1'b0;
		ev_font_d  = '0;
		ev_glyph_d = '0;
		rem_d      = '0;
		unique case (op_q)
			lgc_pkg::OP_LOOKUP: begin
				if (!font_res.found) begin
					status_d = lgc_pkg::ST_NOT_FOUND;
				end else if (g_any) begin
					hit_d  = 1'b1;
					slot_d = lgc_pkg::SLOT_W'(gidx);
				end else begin
					slot_d     = lgc_pkg::SLOT_W'(tidx);
					ev_valid_d = evict;
					if (evict) begin
						ev_font_d  = lru_font;
						ev_glyph_d = lru_glyph;
					end
				end
			end
			lgc_pkg::OP_UNCACHE_GLYPH: begin
				if (g_any) begin
					rem_d = lgc_pkg::REM_W'(1);
				end else begin
					status_d = lgc_pkg::ST_NOT_FOUND;
				end
			end
			lgc_pkg::OP_UNCACHE_FONT: begin
				if (font_res.found) begin
					rem_d = lgc_pkg::REM_W'(rem_cnt_q);
				end else begin
					status_d = lgc_pkg::ST_NOT_FOUND;
				end
			end
			lgc_pkg::OP_CHECK_SIZE: begin
				if (font_res.found) begin
					rem_d = lgc_pkg::REM_W'(rem_cnt_q);
				end else if (font_res.full) begin
					status_d = lgc_pkg::ST_FULL;
				end
			end
			default: begin
				status_d = lgc_pkg::ST_OK;
			end
		endcase
	end

	// slot valid bits, age ranks and used count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q  <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < SLOTS; i++) begin
				if (upd_hit) begin
					if (gm[i]) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (rank_q[i] < grank)) begin
						rank_q[i] <= rank_q[i] + 1'b1;
					end
				end else if (upd_fill) begin
					if (tgt_oh[i]) begin
						valid_q[i] <= 1'b1;
						rank_q[i]  <= '0;
					end else if (valid_q[i]) begin
						rank_q[i] <= rank_q[i] + 1'b1;
					end
				end else if (upd_rm) begin
					if (rm_oh[i]) begin
						valid_q[i] <= 1'b0;
						rank_q[i]  <= '0;
					end else if (valid_q[i] && (rank_q[i] > rm_rank)) begin
						rank_q[i] <= rank_q[i] - 1'b1;
					end
				end
			end
			if (upd_fill && !evict) begin
				used_q <= used_q + 1'b1;
			end else if (upd_rm) begin
				used_q <= used_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < SLOTS; i++) begin
			if (upd_fill && tgt_oh[i]) begin
				font_q[i] <= font_id_q;
				cp_q[i]   <= glyph_q;
			end
		end
	end

	// request hold, flush counter, config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_q <= 1'b0;
			rem_cnt_q   <= '0;
			capacity_q  <= lgc_pkg::CAP_RESET;
		end else begin
			if (accept) begin
				req_valid_q <= 1'b1;
				rem_cnt_q   <= '0;
			end else if (finish) begin
				req_valid_q <= 1'b0;
			end else if (flush_step) begin
				rem_cnt_q <= rem_cnt_q + 1'b1;
			end
			if (cfg.valid) begin
				capacity_q <= cfg.capacity;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= req.op;
			font_id_q   <= req.font_id;
			glyph_q     <= req.glyph;
			font_size_q <= req.font_size;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			status_q   <= status_d;
			hit_q      <= hit_d;
			slot_q     <= slot_d;
			ev_valid_q <= ev_valid_d;
			ev_font_q  <= ev_font_d;
			ev_glyph_q <= ev_glyph_d;
			rem_q      <= rem_d;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = status_q;
	assign rsp.hit           = hit_q;
	assign rsp.slot          = slot_q;
	assign rsp.evicted_valid = ev_valid_q;
	assign rsp.evicted_font  = ev_font_q;
	assign rsp.evicted_glyph = ev_glyph_q;
	assign rsp.removed_count = rem_q;

`ifndef SYNTHESIS
	a_used_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		CW'($countones(valid_q)) == used_q)
		else $error("used count differs from number of valid slots");

	a_tags_unique: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid_q |-> $onehot0(gm))
		else $error("glyph tag cached in more than one slot");

	a_fill_one_target: assert property (@(posedge clk) disable iff (!arst_n)
		upd_fill |-> $onehot(tgt_oh))
		else $error("fill without exactly one target slot");

	a_flush_holds_request: assert property (@(posedge clk) disable iff (!arst_n)
		flush_step |=> req_valid_q && $stable(op_q) && $stable(font_id_q))
		else $error("request dropped during font flush");
`endif

endmodule

`default_nettype wire

// ----- bench/glyph_tag_check_pkg.sv -----
`timescale 1ns / 100ps

package glyph_tag_check_pkg;

	import lgc_pkg::*;

	localparam int SLOTS = 64;
	localparam int FONTS = 8;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [FONT_W-1:0]  font_id;
		logic [GLYPH_W-1:0] glyph;
		logic [SIZE_W-1:0]  font_size;
	} glyph_request_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                hit;
		logic [SLOT_W-1:0]   slot;
		logic                evicted_valid;
		logic [FONT_W-1:0]   evicted_font;
		logic [GLYPH_W-1:0]  evicted_glyph;
		logic [REM_W-1:0]    removed_count;
	} glyph_reply_t;

	class glyph_tag_tracker;
		bit                 slot_valid [SLOTS];
		bit [FONT_W-1:0]    slot_font [SLOTS];
		bit [GLYPH_W-1:0]   slot_code [SLOTS];
		int unsigned        slot_rank [SLOTS];
		bit                 font_known [FONTS];
		bit [FONT_W-1:0]    font_tag [FONTS];
		bit [SIZE_W-1:0]    font_size_seen [FONTS];
		int unsigned        used_count;
		bit [CAP_W-1:0]     capacity;

		glyph_reply_t       replies_due [$];

		int errors;
		int n_requests;
		int n_replies;
		int n_hits;
		int n_fills;
		int n_evictions;
		int n_removed;
		int n_full;
		int n_not_found;
		int n_cap_writes;

		function new();
			capacity = CAP_RESET;
		endfunction

		function void set_capacity(bit [CAP_W-1:0] v);
			capacity = v;
			n_cap_writes++;
		endfunction

		function int font_index(bit [FONT_W-1:0] f);
			for (int i = 0; i < FONTS; i++)
				if (font_known[i] && font_tag[i] == f)
					return i;
			return -1;
		endfunction

		function int glyph_index(bit [FONT_W-1:0] f, bit [GLYPH_W-1:0] g);
			for (int i = 0; i < SLOTS; i++)
				if (slot_valid[i] && slot_font[i] == f && slot_code[i] == g)
					return i;
			return -1;
		endfunction

		// close the gap in the age order left by the removed slot
		function void drop_slot(int s);
			int unsigned rk;
			rk = slot_rank[s];
			slot_valid[s] = 1'b0;
			slot_rank[s] = 0;
			for (int i = 0; i < SLOTS; i++)
				if (slot_valid[i] && slot_rank[i] > rk)
					slot_rank[i]--;
			if (used_count > 0)
				used_count--;
		endfunction

		function int unsigned flush_font(bit [FONT_W-1:0] f);
			int unsigned n;
			n = 0;
			for (int i = 0; i < SLOTS; i++)
				if (slot_valid[i] && slot_font[i] == f) begin
					drop_slot(i);
					n++;
				end
			return n;
		endfunction

		function void apply_request(glyph_request_t r);
			glyph_reply_t e;
			int fi;
			int s;
			int t;
			int unsigned rk;
			int unsigned best;
			int unsigned cap;
			e = '0;
			fi = font_index(r.font_id);
			n_requests++;
			case (r.op)
				OP_LOOKUP: begin
					if (fi < 0) begin
						e.status = ST_NOT_FOUND;
					end else begin
						s = glyph_index(r.font_id, r.glyph);
						if (s >= 0) begin
							rk = slot_rank[s];
							for (int i = 0; i < SLOTS; i++)
								if (slot_valid[i] && slot_rank[i] < rk)
									slot_rank[i]++;
							slot_rank[s] = 0;
							e.hit = 1'b1;
							e.slot = SLOT_W'(s);
							n_hits++;
						end else begin
							cap = (capacity == 0) ? 1 : capacity;
							if (cap > SLOTS)
								cap = SLOTS;
							t = -1;
							best = 0;
							if (used_count >= cap) begin
								for (int i = 0; i < SLOTS; i++)
									if (slot_valid[i] && (t < 0 || slot_rank[i] > best)) begin
										t = i;
										best = slot_rank[i];
									end
								if (t >= 0) begin
									e.evicted_valid = 1'b1;
									e.evicted_font = slot_font[t];
									e.evicted_glyph = slot_code[t];
									drop_slot(t);
									n_evictions++;
								end
							end
							if (t < 0)
								for (int i = 0; i < SLOTS; i++)
									if (!slot_valid[i]) begin
										t = i;
										break;
									end
							if (t < 0)
								t = 0;
							for (int i = 0; i < SLOTS; i++)
								if (slot_valid[i])
									slot_rank[i]++;
							slot_valid[t] = 1'b1;
							slot_font[t] = r.font_id;
							slot_code[t] = r.glyph;
							slot_rank[t] = 0;
							used_count++;
							e.slot = SLOT_W'(t);
							n_fills++;
						end
					end
				end
				OP_UNCACHE_GLYPH: begin
					s = glyph_index(r.font_id, r.glyph);
					if (s >= 0) begin
						drop_slot(s);
						e.removed_count = REM_W'(1);
					end else begin
						e.status = ST_NOT_FOUND;
					end
				end
				OP_UNCACHE_FONT: begin
					if (fi < 0) begin
						e.status = ST_NOT_FOUND;
					end else begin
						e.removed_count = REM_W'(flush_font(r.font_id));
						font_known[fi] = 1'b0;
					end
				end
				default: begin
					if (fi >= 0) begin
						if (font_size_seen[fi] != r.font_size) begin
							e.removed_count = REM_W'(flush_font(r.font_id));
							font_size_seen[fi] = r.font_size;
						end
					end else begin
						t = -1;
						for (int i = 0; i < FONTS; i++)
							if (!font_known[i]) begin
								t = i;
								break;
							end
						if (t < 0) begin
							e.status = ST_FULL;
						end else begin
							font_known[t] = 1'b1;
							font_tag[t] = r.font_id;
							font_size_seen[t] = r.font_size;
						end
					end
				end
			endcase
			if (e.status == ST_FULL)
				n_full++;
			if (e.status == ST_NOT_FOUND)
				n_not_found++;
			n_removed += e.removed_count;
			replies_due.push_back(e);
		endfunction

		task report_error(string msg);
			if (errors < 40)
				$display("ERROR: %s", msg);
			errors++;
		endtask

		task compare_field(string name, int unsigned got, int unsigned want);
			if (got != want)
				report_error($sformatf("reply %0d field %s got 0x%0h, want 0x%0h",
					n_replies, name, got, want));
		endtask

		task check_reply(glyph_reply_t got);
			glyph_reply_t want;
			if (replies_due.size() == 0) begin
				report_error($sformatf("reply %0d came with no request outstanding", n_replies));
			end else begin
				want = replies_due.pop_front();
				compare_field("status", got.status, want.status);
				compare_field("hit", got.hit, want.hit);
				compare_field("slot", got.slot, want.slot);
				compare_field("evicted_valid", got.evicted_valid, want.evicted_valid);
				compare_field("evicted_font", got.evicted_font, want.evicted_font);
				compare_field("evicted_glyph", got.evicted_glyph, want.evicted_glyph);
				compare_field("removed_count", got.removed_count, want.removed_count);
			end
			n_replies++;
		endtask

		task finish_check();
			if (replies_due.size() != 0)
				report_error($sformatf("%0d replies never arrived", replies_due.size()));
		endtask
	endclass

endpackage

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;

	import lgc_pkg::*;
	import glyph_tag_check_pkg::*;

	logic clk;
	logic arst_n;

	lgc_req_if req_ch ();
	lgc_rsp_if rsp_ch ();
	lgc_cfg_if cfg_ch ();

	lru_glyph_cache_tags #(
		.SLOTS(SLOTS),
		.FONTS(FONTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	glyph_tag_tracker tracker = new();

	// small pools so that fonts register, glyphs hit and the table fills up
	bit [FONT_W-1:0]  font_pool [12];
	bit [GLYPH_W-1:0] glyph_pool [20];
	bit [SIZE_W-1:0]  size_pool [3];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("Mismatches found");
		$finish;
	end

	always @(posedge clk) begin : watch
		glyph_reply_t got;
		glyph_request_t sent;
		if (arst_n) begin
			// a reply always trails its request, so check before noting the new one
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.status = rsp_ch.status;
				got.hit = rsp_ch.hit;
				got.slot = rsp_ch.slot;
				got.evicted_valid = rsp_ch.evicted_valid;
				got.evicted_font = rsp_ch.evicted_font;
				got.evicted_glyph = rsp_ch.evicted_glyph;
				got.removed_count = rsp_ch.removed_count;
				tracker.check_reply(got);
			end
			if (req_ch.valid && req_ch.ready) begin
				sent.op = req_ch.op;
				sent.font_id = req_ch.font_id;
				sent.glyph = req_ch.glyph;
				sent.font_size = req_ch.font_size;
				tracker.apply_request(sent);
			end
		end
	end

	// receiver back-pressure: runs of always-ready, a repeating mask, coin flips, heavy stall
	initial begin : rsp_stall
		int mode;
		logic [15:0] mask;
		int k;
		rsp_ch.ready <= 1'b0;
		k = 0;
		forever begin
			mode = $urandom_range(0, 3);
			mask = 16'($urandom) | 16'h1;
			repeat ($urandom_range(20, 150)) begin
				@(posedge clk);
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= mask[k % 16];
					2: rsp_ch.ready <= 1'($urandom_range(0, 1));
					default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
				endcase
				k++;
			end
		end
	end

	task automatic send_request(input logic [OP_W-1:0] op, input logic [FONT_W-1:0] font,
		input logic [GLYPH_W-1:0] glyph, input logic [SIZE_W-1:0] size);
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.font_id <= font;
		req_ch.glyph <= glyph;
		req_ch.font_size <= size;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		// let the watcher note the last accepted request first
		@(posedge clk);
		while (tracker.replies_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.capacity <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		tracker.set_capacity(v);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic refresh_pools();
		foreach (font_pool[i])
			font_pool[i] = FONT_W'($urandom);
		foreach (glyph_pool[i])
			glyph_pool[i] = GLYPH_W'($urandom);
		foreach (size_pool[i])
			size_pool[i] = SIZE_W'($urandom);
	endtask

	// free the font table of fonts that the next pool would never reach
	task automatic release_fonts();
		logic [FONT_W-1:0] fixed_fonts [6];
		fixed_fonts = '{8'd5, 8'd1, 8'd2, 8'd3, 8'd4, 8'd6};
		foreach (fixed_fonts[i])
			send_request(OP_UNCACHE_FONT, fixed_fonts[i], '0, '0);
		foreach (font_pool[i])
			send_request(OP_UNCACHE_FONT, font_pool[i], '0, '0);
	endtask

	task automatic send_random();
		int pick;
		logic [OP_W-1:0] op;
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			send_request(OP_W'($urandom), FONT_W'($urandom), GLYPH_W'($urandom),
				SIZE_W'($urandom));
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 68)
				op = OP_LOOKUP;
			else if (pick < 78)
				op = OP_UNCACHE_GLYPH;
			else if (pick < 83)
				op = OP_UNCACHE_FONT;
			else
				op = OP_CHECK_SIZE;
			send_request(op, font_pool[$urandom_range(0, 11)],
				glyph_pool[$urandom_range(0, 19)], size_pool[$urandom_range(0, 2)]);
		end
	endtask

	task automatic run_random(input int n);
		int sent;
		int burst;
		int gap;
		sent = 0;
		while (sent < n) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst && sent < n; i++) begin
				send_random();
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0 && sent < n) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic run_directed();
		logic [FONT_W-1:0] more_fonts [7];
		more_fonts = '{8'd0, 8'd255, 8'd1, 8'd2, 8'd3, 8'd4, 8'd6};
		send_request(OP_LOOKUP, 8'd5, 21'd7, 10'd0);          // font not registered
		send_request(OP_UNCACHE_GLYPH, 8'd5, 21'd7, 10'd0);
		send_request(OP_UNCACHE_FONT, 8'd5, 21'd0, 10'd0);
		send_request(OP_CHECK_SIZE, 8'd5, 21'd0, 10'd0);      // registers the font
		send_request(OP_CHECK_SIZE, 8'd5, 21'd0, 10'd0);      // size unchanged
		send_request(OP_LOOKUP, 8'd5, 21'd0, 10'd0);
		send_request(OP_LOOKUP, 8'd5, 21'h1FFFFF, 10'h3FF);
		send_request(OP_LOOKUP, 8'd5, 21'd0, 10'd0);          // hit
		foreach (more_fonts[i])
			send_request(OP_CHECK_SIZE, more_fonts[i], 21'd0, (i == 0) ? 10'h3FF : 10'(i));
		send_request(OP_CHECK_SIZE, 8'd7, 21'd0, 10'd0);      // font table full
		wait_idle();
		write_capacity(7'd2);
		send_request(OP_LOOKUP, 8'd0, 21'd3, 10'd0);          // evicts least recent
		send_request(OP_LOOKUP, 8'd255, 21'h10FFFF, 10'd0);
		send_request(OP_UNCACHE_GLYPH, 8'd255, 21'h10FFFF, 10'd0);
		send_request(OP_LOOKUP, 8'd0, 21'd4, 10'd0);
		send_request(OP_CHECK_SIZE, 8'd0, 21'd0, 10'd9);      // size change flushes
		send_request(OP_UNCACHE_FONT, 8'd0, 21'd0, 10'd0);
		send_request(OP_UNCACHE_FONT, 8'd255, 21'd0, 10'd0);
		wait_idle();
		write_capacity(7'd0);                                // zero behaves as one
		send_request(OP_LOOKUP, 8'd5, 21'd1, 10'd0);
		send_request(OP_LOOKUP, 8'd5, 21'd2, 10'd0);
		wait_idle();
	endtask

	initial begin : main
		logic [CAP_W-1:0] caps [8];
		int w;
		caps = '{7'd64, 7'd5, 7'd127, 7'd1, 7'd0, 7'd33, 7'd64, 7'd2};
		caps[5] = CAP_W'($urandom_range(1, 64));
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.op <= OP_LOOKUP;
		req_ch.font_id <= '0;
		req_ch.glyph <= '0;
		req_ch.font_size <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.capacity <= CAP_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		foreach (caps[p]) begin
			write_capacity(caps[p]);
			release_fonts();
			refresh_pools();
			run_random(186);
			wait_idle();
		end

		req_ch.valid <= 1'b0;
		w = 0;
		while (tracker.replies_due.size() != 0 && w < 20000) begin
			@(posedge clk);
			w++;
		end
		repeat (80) @(posedge clk);
		tracker.finish_check();

		$display("covered %0d requests: %0d hits, %0d fills, %0d evictions, %0d entries removed",
			tracker.n_requests, tracker.n_hits, tracker.n_fills, tracker.n_evictions,
			tracker.n_removed);
		$display("%0d capacity writes, %0d table-full and %0d not-found replies, %0d replies",
			tracker.n_cap_writes, tracker.n_full, tracker.n_not_found, tracker.n_replies);
		if (tracker.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
